// File: hw/rtl/plqm_pkg.sv
// Package for the pooled linked queue manager: transaction payloads, operation
// codes, controller states, micro-operations and the controller/datapath bundles.
// No dependencies.
`default_nettype none

package plqm_pkg;

  localparam int unsigned POOL_SIZE_DEF  = 32;
  localparam int unsigned NUM_QUEUES_DEF = 8;

  typedef enum logic [3:0] {
    FN_ALLOC        = 4'd0,
    FN_FREE         = 4'd1,
    FN_INSERT       = 4'd2,
    FN_REMOVE_HEAD  = 4'd3,
    FN_REMOVE_ENTRY = 4'd4,
    FN_HEAD         = 4'd5,
    FN_ADD_CHILD    = 4'd6,
    FN_REMOVE_CHILD = 4'd7,
    FN_DETACH       = 4'd8,
    FN_CHILD_QUERY  = 4'd9
  } func_e;

  typedef struct packed {
    logic [3:0] func;
    logic [2:0] queue_id;
    logic [4:0] entry;
    logic [4:0] parent;
  } plqm_in_t;

  typedef struct packed {
    logic [4:0] result_entry;
    logic       is_null;
  } plqm_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AL_RD,
    ST_AL_WR,
    ST_FREE,
    ST_TAIL_RD,
    ST_TAIL,
    ST_INS_LINK,
    ST_INS_TAIL,
    ST_HEAD,
    ST_RH_CAP,
    ST_RH_FIX,
    ST_WALK,
    ST_WALK_STEP,
    ST_RE_LINK,
    ST_RE_CLR,
    ST_PAR_RD,
    ST_PAR_CAP,
    ST_FIN
  } plqm_state_e;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_ALLOC_RD,
    UOP_ALLOC_WR,
    UOP_FREE,
    UOP_TAIL_RD,
    UOP_CQ_CAP,
    UOP_INS_EMPTY,
    UOP_TAIL_CAP_RDN,
    UOP_INS_LINK,
    UOP_INS_TAIL,
    UOP_HEAD_CAP,
    UOP_RH_CAP,
    UOP_RH_FIX,
    UOP_WALK_INIT,
    UOP_WALK_RD,
    UOP_WALK_STEP,
    UOP_RE_RD,
    UOP_RE_LINK,
    UOP_RE_CLR,
    UOP_PAR_RD,
    UOP_PAR_CAP
  } plqm_uop_e;

  typedef struct packed {
    logic      load;
    logic      emit;
    plqm_uop_e uop;
  } plqm_cmd_t;

  typedef struct packed {
    func_e func;
    logic  e_ok;
    logic  par_ok;
    logic  q_ok;
    logic  fh_null;
    logic  tail_null;
    logic  nrd_null;
    logic  nrd_is_t;
    logic  walk_hit;
    logic  steps_max;
    logic  par_null;
    logic  out_busy;
  } plqm_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/plqm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module plqm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/plqm_ctrl.sv
// Controller of the pooled linked queue manager: sequences the micro-operations
// of each transaction. Depends on plqm_pkg.
`default_nettype none

module plqm_ctrl import plqm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire plqm_stat_t stat_i,
  output logic            in_stall_o,
  output plqm_cmd_t       cmd_o
);

  plqm_state_e state_q, state_d;
  func_e       op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= FN_ALLOC;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cmd_o      = '{load: 1'b0, emit: 1'b0, uop: UOP_NONE};
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = stat_i.func;
          case (stat_i.func)
            FN_ALLOC:        state_d = ST_AL_RD;
            FN_FREE:         state_d = stat_i.e_ok ? ST_FREE : ST_FIN;
            FN_INSERT,
            FN_REMOVE_ENTRY: state_d = (stat_i.e_ok && stat_i.q_ok) ? ST_TAIL_RD : ST_FIN;
            FN_REMOVE_HEAD,
            FN_HEAD:         state_d = stat_i.q_ok ? ST_TAIL_RD : ST_FIN;
            FN_ADD_CHILD:    state_d = (stat_i.e_ok && stat_i.par_ok) ? ST_TAIL_RD : ST_FIN;
            FN_REMOVE_CHILD,
            FN_CHILD_QUERY:  state_d = stat_i.par_ok ? ST_TAIL_RD : ST_FIN;
            FN_DETACH:       state_d = stat_i.e_ok ? ST_PAR_RD : ST_FIN;
            default:         state_d = ST_FIN;
          endcase
        end
      end
      ST_AL_RD: begin
        if (stat_i.fh_null) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.uop = UOP_ALLOC_RD;
          state_d   = ST_AL_WR;
        end
      end
      ST_AL_WR: begin
        cmd_o.uop = UOP_ALLOC_WR;
        state_d   = ST_FIN;
      end
      ST_FREE: begin
        cmd_o.uop = UOP_FREE;
        state_d   = ST_FIN;
      end
      ST_TAIL_RD: begin
        cmd_o.uop = UOP_TAIL_RD;
        state_d   = ST_TAIL;
      end
      ST_TAIL: begin
        case (op_q)
          FN_CHILD_QUERY: begin
            cmd_o.uop = UOP_CQ_CAP;
            state_d   = ST_FIN;
          end
          FN_INSERT, FN_ADD_CHILD: begin
            if (stat_i.tail_null) begin
              cmd_o.uop = UOP_INS_EMPTY;
              state_d   = ST_FIN;
            end else begin
              cmd_o.uop = UOP_TAIL_CAP_RDN;
              state_d   = ST_INS_LINK;
            end
          end
          FN_REMOVE_HEAD, FN_REMOVE_CHILD, FN_HEAD: begin
            if (stat_i.tail_null) begin
              state_d = ST_FIN;
            end else begin
              cmd_o.uop = UOP_TAIL_CAP_RDN;
              state_d   = (op_q == FN_HEAD) ? ST_HEAD : ST_RH_CAP;
            end
          end
          FN_REMOVE_ENTRY, FN_DETACH: begin
            if (stat_i.tail_null) begin
              state_d = ST_FIN;
            end else begin
              cmd_o.uop = UOP_WALK_INIT;
              state_d   = ST_WALK;
            end
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_INS_LINK: begin
        cmd_o.uop = UOP_INS_LINK;
        state_d   = ST_INS_TAIL;
      end
      ST_INS_TAIL: begin
        cmd_o.uop = UOP_INS_TAIL;
        state_d   = ST_FIN;
      end
      ST_HEAD: begin
        cmd_o.uop = UOP_HEAD_CAP;
        state_d   = ST_FIN;
      end
      ST_RH_CAP: begin
        if (stat_i.nrd_null) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.uop = UOP_RH_CAP;
          state_d   = ST_RH_FIX;
        end
      end
      ST_RH_FIX: begin
        cmd_o.uop = UOP_RH_FIX;
        state_d   = ST_FIN;
      end
      ST_WALK: begin
        if (stat_i.walk_hit) begin
          cmd_o.uop = UOP_RE_RD;
          state_d   = ST_RE_LINK;
        end else if (stat_i.steps_max) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.uop = UOP_WALK_RD;
          state_d   = ST_WALK_STEP;
        end
      end
      ST_WALK_STEP: begin
        if (stat_i.nrd_null || stat_i.nrd_is_t) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.uop = UOP_WALK_STEP;
          state_d   = ST_WALK;
        end
      end
      ST_RE_LINK: begin
        cmd_o.uop = UOP_RE_LINK;
        state_d   = ST_RE_CLR;
      end
      ST_RE_CLR: begin
        cmd_o.uop = UOP_RE_CLR;
        state_d   = ST_FIN;
      end
      ST_PAR_RD: begin
        cmd_o.uop = UOP_PAR_RD;
        state_d   = ST_PAR_CAP;
      end
      ST_PAR_CAP: begin
        if (stat_i.par_null) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.uop = UOP_PAR_CAP;
          state_d   = ST_TAIL_RD;
        end
      end
      ST_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/plqm_dpath.sv
// Datapath of the pooled linked queue manager: link RAMs, valid bits, queue
// tails, free-list head, work registers and output register.
// Depends on plqm_pkg and plqm_ram.
`default_nettype none

module plqm_dpath import plqm_pkg::*; #(
  parameter int unsigned POOL_SIZE  = POOL_SIZE_DEF,
  parameter int unsigned NUM_QUEUES = NUM_QUEUES_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire plqm_in_t  in_data_i,
  input  wire logic      out_stall_i,
  input  wire plqm_cmd_t cmd_i,
  output plqm_stat_t     stat_o,
  output logic           out_valid_o,
  output plqm_out_t      out_data_o
);

  localparam int unsigned IW = $clog2(POOL_SIZE);
  localparam int unsigned LW = IW + 1;
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned SW = $clog2(POOL_SIZE + 1);
  localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};

  // link values carry a null flag in the top bit
  logic [LW-1:0] fh_q;
  logic [LW-1:0] qt_q [NUM_QUEUES];
  logic [POOL_SIZE-1:0] nv_q, par_v_q, cv_q;

  logic [IW-1:0] e_q, ptr_q;
  logic [QW-1:0] qidx_q;
  logic          chld_q;
  logic [LW-1:0] res_q, t_q, walk_q, nx_q, rm_q, pv_q;
  logic [SW-1:0] steps_q;
  logic [IW-1:0] n_raddr_q, c_raddr_q, pa_raddr_q;
  logic          out_valid_q;
  plqm_out_t     out_q;

  logic          n_we, n_re, p_we, p_re, pa_we, pa_re, c_re, tail_we;
  logic [IW-1:0] n_wa, n_ra, p_wa, p_ra, pa_wa, pa_ra, c_ra;
  logic [LW-1:0] n_wd, p_wd, tail_wd, n_rdata, prd;
  logic [IW-1:0] pa_wd, pa_rdata, c_rdata;
  logic [LW-1:0] nrd, tail_v, pa_rd;
  logic [LW-1:0] e_link;
  func_e         in_func;

  assign e_link  = {1'b0, e_q};
  assign in_func = func_e'(in_data_i.func);

  plqm_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_next_ram (
    .clk_i, .we_i(n_we), .waddr_i(n_wa), .wdata_i(n_wd),
    .re_i(n_re), .raddr_i(n_ra), .rdata_o(n_rdata)
  );
  plqm_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_prev_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd),
    .re_i(p_re), .raddr_i(p_ra), .rdata_o(prd)
  );
  plqm_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_parent_ram (
    .clk_i, .we_i(pa_we), .waddr_i(pa_wa), .wdata_i(pa_wd),
    .re_i(pa_re), .raddr_i(pa_ra), .rdata_o(pa_rdata)
  );
  plqm_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_child_ram (
    .clk_i, .we_i(chld_q && tail_we && !tail_wd[IW]), .waddr_i(ptr_q),
    .wdata_i(tail_wd[IW-1:0]), .re_i(c_re), .raddr_i(c_ra), .rdata_o(c_rdata)
  );

  // unwritten next links read as their reset chain
  always_comb begin
    if (nv_q[n_raddr_q]) begin
      nrd = n_rdata;
    end else if (32'(n_raddr_q) == POOL_SIZE - 1) begin
      nrd = NIL;
    end else begin
      nrd = {1'b0, IW'(n_raddr_q + 1'b1)};
    end
  end

  assign pa_rd  = par_v_q[pa_raddr_q] ? {1'b0, pa_rdata} : NIL;
  assign tail_v = chld_q ? (cv_q[c_raddr_q] ? {1'b0, c_rdata} : NIL) : qt_q[qidx_q];

  always_comb begin
    n_we = 1'b0; n_wa = e_q; n_wd = NIL; n_re = 1'b0; n_ra = e_q;
    p_we = 1'b0; p_wa = e_q; p_wd = NIL; p_re = 1'b0; p_ra = e_q;
    pa_we = 1'b0; pa_wa = e_q; pa_wd = ptr_q; pa_re = 1'b0; pa_ra = e_q;
    c_re = 1'b0; c_ra = ptr_q;
    tail_we = 1'b0; tail_wd = NIL;
    case (cmd_i.uop)
      UOP_ALLOC_RD: begin
        n_re = 1'b1; n_ra = fh_q[IW-1:0];
      end
      UOP_ALLOC_WR: begin
        n_we = 1'b1; n_wa = fh_q[IW-1:0]; n_wd = NIL;
        p_we = 1'b1; p_wa = fh_q[IW-1:0]; p_wd = NIL;
      end
      UOP_FREE: begin
        n_we = 1'b1; n_wd = fh_q;
      end
      UOP_TAIL_RD: begin
        c_re = 1'b1;
      end
      UOP_INS_EMPTY: begin
        n_we = 1'b1; n_wd = e_link;
        p_we = 1'b1; p_wd = e_link;
        tail_we = 1'b1; tail_wd = e_link;
        pa_we = chld_q;
      end
      UOP_TAIL_CAP_RDN: begin
        n_re = 1'b1; n_ra = tail_v[IW-1:0];
      end
      UOP_INS_LINK: begin
        n_we = 1'b1; n_wd = nrd;
        p_we = 1'b1; p_wd = t_q;
      end
      UOP_INS_TAIL: begin
        p_we = !nx_q[IW]; p_wa = nx_q[IW-1:0]; p_wd = e_link;
        n_we = 1'b1; n_wa = t_q[IW-1:0]; n_wd = e_link;
        tail_we = 1'b1; tail_wd = e_link;
        pa_we = chld_q;
      end
      UOP_RH_CAP: begin
        n_re = 1'b1; n_ra = nrd[IW-1:0];
      end
      UOP_RH_FIX: begin
        n_we = 1'b1; n_wa = t_q[IW-1:0]; n_wd = nrd;
        p_we = !nrd[IW]; p_wa = nrd[IW-1:0]; p_wd = t_q;
        tail_we = (rm_q == t_q); tail_wd = NIL;
      end
      UOP_WALK_RD: begin
        n_re = 1'b1; n_ra = walk_q[IW-1:0];
      end
      UOP_RE_RD: begin
        n_re = 1'b1; p_re = 1'b1;
      end
      UOP_RE_LINK: begin
        p_we = !nrd[IW]; p_wa = nrd[IW-1:0]; p_wd = prd;
        n_we = !prd[IW]; n_wa = prd[IW-1:0]; n_wd = nrd;
      end
      UOP_RE_CLR: begin
        n_we = 1'b1; n_wd = NIL;
        p_we = 1'b1; p_wd = NIL;
        tail_we = (t_q == e_link);
        tail_wd = (pv_q == e_link) ? NIL : pv_q;
      end
      UOP_PAR_RD: begin
        pa_re = 1'b1;
      end
      default: ;
    endcase
  end

  // control state: free-list head, queue tails, valid bits, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q        <= {1'b0, {IW{1'b0}}};
      nv_q        <= '0;
      par_v_q     <= '0;
      cv_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        qt_q[i] <= NIL;
      end
    end else begin
      if (cmd_i.uop == UOP_ALLOC_WR) begin
        fh_q                    <= nrd;
        par_v_q[fh_q[IW-1:0]]   <= 1'b0;
        cv_q[fh_q[IW-1:0]]      <= 1'b0;
      end else if (cmd_i.uop == UOP_FREE) begin
        fh_q <= e_link;
      end
      if (n_we) begin
        nv_q[n_wa] <= 1'b1;
      end
      if (pa_we) begin
        par_v_q[pa_wa] <= 1'b1;
      end
      if (tail_we) begin
        if (chld_q) begin
          cv_q[ptr_q] <= !tail_wd[IW];
        end else begin
          qt_q[qidx_q] <= tail_wd;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    if (n_re) n_raddr_q <= n_ra;
    if (c_re) c_raddr_q <= c_ra;
    if (pa_re) pa_raddr_q <= pa_ra;
    if (cmd_i.load) begin
      e_q    <= IW'(in_data_i.entry);
      ptr_q  <= IW'(in_data_i.parent);
      qidx_q <= QW'(in_data_i.queue_id);
      chld_q <= (in_func == FN_ADD_CHILD) || (in_func == FN_REMOVE_CHILD) ||
                (in_func == FN_DETACH) || (in_func == FN_CHILD_QUERY);
      res_q  <= NIL;
    end
    if (cmd_i.emit) begin
      out_q.result_entry <= res_q[IW] ? 5'd0 : 5'(res_q[IW-1:0]);
      out_q.is_null      <= res_q[IW];
    end
    case (cmd_i.uop)
      UOP_ALLOC_WR:     res_q <= fh_q;
      UOP_CQ_CAP:       res_q <= {tail_v[IW], {IW{1'b0}}};
      UOP_TAIL_CAP_RDN: t_q <= tail_v;
      UOP_INS_LINK:     nx_q <= nrd;
      UOP_HEAD_CAP:     res_q <= nrd;
      UOP_RH_CAP:       rm_q <= nrd;
      UOP_RH_FIX:       res_q <= rm_q;
      UOP_WALK_INIT: begin
        t_q     <= tail_v;
        walk_q  <= tail_v;
        steps_q <= '0;
      end
      UOP_WALK_STEP: begin
        walk_q  <= nrd;
        steps_q <= steps_q + 1'b1;
      end
      UOP_RE_LINK:      pv_q <= prd;
      UOP_RE_CLR:       res_q <= e_link;
      UOP_PAR_CAP:      ptr_q <= pa_rd[IW-1:0];
      default: ;
    endcase
  end

  always_comb begin
    stat_o.func      = in_func;
    stat_o.e_ok      = 32'(in_data_i.entry) < POOL_SIZE;
    stat_o.par_ok    = 32'(in_data_i.parent) < POOL_SIZE;
    stat_o.q_ok      = 32'(in_data_i.queue_id) < NUM_QUEUES;
    stat_o.fh_null   = fh_q[IW];
    stat_o.tail_null = tail_v[IW];
    stat_o.nrd_null  = nrd[IW];
    stat_o.nrd_is_t  = (nrd == t_q);
    stat_o.walk_hit  = (walk_q == e_link);
    stat_o.steps_max = (steps_q == SW'(POOL_SIZE));
    stat_o.par_null  = pa_rd[IW];
    stat_o.out_busy  = out_valid_q && out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/pooled_linked_queue_manager_unit.sv
// Top level of the pooled linked queue manager: controller plus datapath.
// Depends on plqm_pkg, plqm_ctrl, plqm_dpath (and plqm_ram below it).
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  in_data_i  (plqm_in_t)
//   out      output     out_valid_o / out_stall_i out_data_o (plqm_out_t)
//
// One transaction is taken at a time. Remove entry and detach also search for
// the entry, starting at the tail and following one next link per step. Every
// dependent link hop has to pass through the single registered read port on
// each link RAM, which sets the pace of each transaction.
// Reset is immediate: the free chain and empty child lists come from valid bits, and queue tails reset to null.
// A result held under out_stall_i does not block the next input transaction;
// only a second finished result waits for the output register to drain.
`default_nettype none

module pooled_linked_queue_manager_unit import plqm_pkg::*; #(
  parameter int unsigned POOL_SIZE  = POOL_SIZE_DEF,
  parameter int unsigned NUM_QUEUES = NUM_QUEUES_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire plqm_in_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output plqm_out_t     out_data_o
);

  plqm_cmd_t  cmd;
  plqm_stat_t stat;

  // sequence the micro-operations of each transaction
  plqm_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .stat_i    (stat),
    .in_stall_o,
    .cmd_o     (cmd)
  );

  // hold the link memories and advance the work registers
  plqm_dpath #(
    .POOL_SIZE (POOL_SIZE),
    .NUM_QUEUES(NUM_QUEUES)
  ) u_dpath (
    .clk_i,
    .rst_ni,
    .in_data_i,
    .out_stall_i,
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o,
    .out_data_o
  );

endmodule

`default_nettype wire
